// File: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue: opcodes, result
// status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int SPQ_CAPACITY = 64;
  localparam int SPQ_TAG_BITS = 16;
  localparam int PRI_BITS     = 4;
  localparam int STAT_BITS    = 2;

  typedef enum logic [0:0] {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } spq_op_t;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } spq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_EXT,
    S_FIN
  } spq_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // take the input item
    logic shift;     // move the scanned entry up one slot
    logic place;     // write the new entry at the scan index
    logic ext_head;  // reload the head from the read data
    logic fin;       // load the result register
  } spq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic extract;   // opcode of the item at the input
    logic full;
    logic empty;
    logic one;       // exactly one entry stored
    logic shift_ok;  // scanned entry has priority >= new entry
    logic idx_one;   // scan index is at slot 1
    logic out_busy;  // result register holds an item not taken this cycle
  } spq_stat_t;

endpackage

// File: rtl/core/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the priority queue: takes one item, steps the insert scan or
// the extract head reload, then hands the result to the output register.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  spq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!stat.extract) begin
            if (stat.full) begin
              state_nxt = S_FIN;
            end else if (stat.empty) begin
              state_nxt = S_PLACE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            if (stat.empty || stat.one) begin
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_EXT;
            end
          end
        end
      end
      S_SCAN: begin
        if (stat.shift_ok) begin
          cmd.shift = 1'b1;
          state_nxt = stat.idx_one ? S_PLACE : S_SCAN;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_FIN;
      end
      S_EXT: begin
        cmd.ext_head = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        // hold until the result register is free
        if (!stat.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.shift, cmd.place, cmd.ext_head, cmd.fin}))
    else $error("spq_ctrl: more than one command in a cycle");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> state_r == S_IDLE)
    else $error("spq_ctrl: no return to idle after result");

  a_place_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |=> state_r == S_FIN)
    else $error("spq_ctrl: place not followed by result");

endmodule

// File: rtl/core/spq_dpath.sv
// ----------------------------------------------------------------------------
// spq_dpath
// Datapath of the priority queue: slot memory, entry count, scan index,
// cached head entry and the result register.
// ----------------------------------------------------------------------------
module spq_dpath #(
  parameter int CAPACITY = spq_pkg::SPQ_CAPACITY,
  parameter int TAG_BITS = spq_pkg::SPQ_TAG_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [0:0]                        in_opcode,
  input  logic [spq_pkg::PRI_BITS-1:0]      in_priority,
  input  logic [TAG_BITS-1:0]               in_tag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [spq_pkg::STAT_BITS-1:0]     out_status,
  output logic [spq_pkg::PRI_BITS-1:0]      out_priority,
  output logic [TAG_BITS-1:0]               out_tag,
  output logic                              out_head_valid,
  output logic [spq_pkg::PRI_BITS-1:0]      out_head_priority,
  output logic [TAG_BITS-1:0]               out_head_tag,
  output logic [$clog2(CAPACITY+1)-1:0]     out_entry_count,
  input  spq_pkg::spq_cmd_t                 cmd,
  output spq_pkg::spq_stat_t                stat
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int EW = PRI_BITS + TAG_BITS;

  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [PRI_BITS-1:0]  pri_r, pri_nxt;
  logic [TAG_BITS-1:0]  tag_r, tag_nxt;
  logic [PRI_BITS-1:0]  head_pri_r, head_pri_nxt;
  logic [TAG_BITS-1:0]  head_tag_r, head_tag_nxt;
  logic [STAT_BITS-1:0] res_stat_r, res_stat_nxt;
  logic [PRI_BITS-1:0]  res_pri_r, res_pri_nxt;
  logic [TAG_BITS-1:0]  res_tag_r, res_tag_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_BITS-1:0] o_stat_r, o_stat_nxt;
  logic [PRI_BITS-1:0]  o_pri_r, o_pri_nxt;
  logic [TAG_BITS-1:0]  o_tag_r, o_tag_nxt;
  logic                 o_hv_r, o_hv_nxt;
  logic [PRI_BITS-1:0]  o_hpri_r, o_hpri_nxt;
  logic [TAG_BITS-1:0]  o_htag_r, o_htag_nxt;
  logic [CW-1:0]        o_cnt_r, o_cnt_nxt;

  logic                 is_ext, full, empty;
  logic [CW-1:0]        raddr_full;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic [EW-1:0]        ram_rdata;
  logic [PRI_BITS-1:0]  rd_pri;
  logic [TAG_BITS-1:0]  rd_tag;

  assign is_ext = (in_opcode == OP_EXTRACT);
  assign full   = (count_r == CW'(CAPACITY));
  assign empty  = (count_r == '0);
  assign rd_pri = ram_rdata[EW-1:TAG_BITS];
  assign rd_tag = ram_rdata[TAG_BITS-1:0];

  // read the current top on insert, the slot below the top on extract,
  // and two below the scan index while scanning
  always_comb begin
    if (cmd.load) begin
      raddr_full = is_ext ? count_r - CW'(2) : count_r - CW'(1);
    end else begin
      raddr_full = idx_r - CW'(2);
    end
  end

  assign ram_we    = cmd.shift | cmd.place;
  assign ram_waddr = idx_r[AW-1:0];
  assign ram_wdata = cmd.shift ? ram_rdata : {pri_r, tag_r};

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (1'b1),
    .raddr (raddr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    pri_nxt      = pri_r;
    tag_nxt      = tag_r;
    head_pri_nxt = head_pri_r;
    head_tag_nxt = head_tag_r;
    res_stat_nxt = res_stat_r;
    res_pri_nxt  = res_pri_r;
    res_tag_nxt  = res_tag_r;

    if (cmd.load) begin
      pri_nxt      = in_priority;
      tag_nxt      = in_tag;
      idx_nxt      = count_r;
      res_stat_nxt = STAT_OK;
      res_pri_nxt  = '0;
      res_tag_nxt  = '0;
      if (!is_ext && full) begin
        res_stat_nxt = STAT_FULL;
      end else if (is_ext && empty) begin
        res_stat_nxt = STAT_EMPTY;
      end else if (is_ext) begin
        res_pri_nxt = head_pri_r;
        res_tag_nxt = head_tag_r;
        count_nxt   = count_r - CW'(1);
      end
    end

    if (cmd.shift) begin
      idx_nxt = idx_r - CW'(1);
    end

    if (cmd.place) begin
      count_nxt = count_r + CW'(1);
      // new entry lands on top: it becomes the head
      if (idx_r == count_r) begin
        head_pri_nxt = pri_r;
        head_tag_nxt = tag_r;
      end
    end

    if (cmd.ext_head) begin
      head_pri_nxt = rd_pri;
      head_tag_nxt = rd_tag;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    o_stat_nxt    = o_stat_r;
    o_pri_nxt     = o_pri_r;
    o_tag_nxt     = o_tag_r;
    o_hv_nxt      = o_hv_r;
    o_hpri_nxt    = o_hpri_r;
    o_htag_nxt    = o_htag_r;
    o_cnt_nxt     = o_cnt_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
      o_stat_nxt    = res_stat_r;
      o_pri_nxt     = res_pri_r;
      o_tag_nxt     = res_tag_r;
      o_hv_nxt      = !empty;
      o_hpri_nxt    = empty ? '0 : head_pri_r;
      o_htag_nxt    = empty ? '0 : head_tag_r;
      o_cnt_nxt     = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pri_r      <= pri_nxt;
    tag_r      <= tag_nxt;
    head_pri_r <= head_pri_nxt;
    head_tag_r <= head_tag_nxt;
    res_stat_r <= res_stat_nxt;
    res_pri_r  <= res_pri_nxt;
    res_tag_r  <= res_tag_nxt;
    o_stat_r   <= o_stat_nxt;
    o_pri_r    <= o_pri_nxt;
    o_tag_r    <= o_tag_nxt;
    o_hv_r     <= o_hv_nxt;
    o_hpri_r   <= o_hpri_nxt;
    o_htag_r   <= o_htag_nxt;
    o_cnt_r    <= o_cnt_nxt;
  end

  always_comb begin
    stat          = '0;
    stat.extract  = is_ext;
    stat.full     = full;
    stat.empty    = empty;
    stat.one      = (count_r == CW'(1));
    stat.shift_ok = (rd_pri >= pri_r);
    stat.idx_one  = (idx_r == CW'(1));
    stat.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = o_stat_r;
  assign out_priority      = o_pri_r;
  assign out_tag           = o_tag_r;
  assign out_head_valid    = o_hv_r;
  assign out_head_priority = o_hpri_r;
  assign out_head_tag      = o_htag_r;
  assign out_entry_count   = o_cnt_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("spq_dpath: entry count above capacity");

  a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |-> (count_r < CW'(CAPACITY)) && (idx_r <= count_r))
    else $error("spq_dpath: placement without room or past the top");

  a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> idx_r != '0)
    else $error("spq_dpath: shift below slot zero");

  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid_r)
    else $error("spq_dpath: result not presented");

endmodule

// File: rtl/core/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Sorted-list priority queue with stable ordering among equal priorities.
// ----------------------------------------------------------------------------
// Entries sit in one slot memory in ascending priority order, the head at the
// top slot and also cached in registers. One memory read reloads the new head
// on an extract, unless the extract empties the queue or finds it empty.
// An insert scans down from the top, moving every stored entry with priority
// equal to or above the new one up one slot, one entry per cycle, through the
// single read and write port of the slot memory. A rejected insert into a
// full queue skips the scan. Results sit in an output register, so the next
// item is taken while the last result waits; its own result then waits while
// the output register still holds an item that has not been taken. Reset
// leaves the slot memory as it is; only the count, the output valid flag and
// the controller state are cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int CAPACITY = spq_pkg::SPQ_CAPACITY,
  parameter int TAG_BITS = spq_pkg::SPQ_TAG_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [0:0]                    in_opcode,
  input  logic [spq_pkg::PRI_BITS-1:0]  in_priority,
  input  logic [TAG_BITS-1:0]           in_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [spq_pkg::STAT_BITS-1:0] out_status,
  output logic [spq_pkg::PRI_BITS-1:0]  out_priority,
  output logic [TAG_BITS-1:0]           out_tag,
  output logic                          out_head_valid,
  output logic [spq_pkg::PRI_BITS-1:0]  out_head_priority,
  output logic [TAG_BITS-1:0]           out_head_tag,
  output logic [$clog2(CAPACITY+1)-1:0] out_entry_count
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_dpath #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_opcode         (in_opcode),
    .in_priority       (in_priority),
    .in_tag            (in_tag),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_priority      (out_priority),
    .out_tag           (out_tag),
    .out_head_valid    (out_head_valid),
    .out_head_priority (out_head_priority),
    .out_head_tag      (out_head_tag),
    .out_entry_count   (out_entry_count),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule
